>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scan binner checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising edge, disabled while reset is low.
`define PCSB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on the rising edge, active during reset too.
`define PCSB_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pcsb_pkg.sv
// ---------------------------------------------------------------------------
// pcsb_pkg
// Types, constants and tables shared by the point cloud scan binner.
// ---------------------------------------------------------------------------
`default_nettype none

package pcsb_pkg;

    localparam int BIN_IDX_W     = 6;
    localparam int SQ_W          = 27;
    localparam int ANG_LIMIT     = 8575;
    localparam int BIN_WIDTH_Q20 = 18093;
    // floor(2^35 / 18093); quotient low by at most one, fixed by one compare
    localparam int RECIP         = 1899062;
    localparam int RECIP_SHIFT   = 35;
    localparam int EMPTY_EXTRA   = 1000;
    localparam int EMPTY_RESET   = 36000000;
    localparam int RANGE_SAT     = 8191;

    localparam logic       REQ_POINT = 1'b0;
    localparam logic       REQ_COUNT = 1'b1;

    localparam logic       CMD_POINT = 1'b0;
    localparam logic       CMD_COUNT = 1'b1;

    localparam logic [2:0] CFG_MIN_HEIGHT  = 3'd0;
    localparam logic [2:0] CFG_MAX_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_RANGE_MIN   = 3'd2;
    localparam logic [2:0] CFG_RANGE_MAX   = 3'd3;
    localparam logic [2:0] CFG_MIN_VISIBLE = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic              point_invalid;
        logic              last_point;
        logic [15:0]       visible_count;
    } in_t;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [12:0] bin_range_mm;
        logic        last_bin;
    } out_t;

    typedef struct packed {
        logic signed [15:0] min_height_mm;
        logic signed [15:0] max_height_mm;
        logic [12:0]        range_min_mm;
        logic [12:0]        range_max_mm;
        logic [15:0]        min_visible;
    } cfg_t;

    typedef struct packed {
        logic                 kind;
        logic                 keep;
        logic                 last;
        logic [BIN_IDX_W-1:0] bin;
        logic [SQ_W-1:0]      rsq;
        logic [15:0]          count;
    } cmd_t;

    // atan(2^-i) in Q2.14 radians
    function automatic logic [13:0] atan_q14(input logic [4:0] i);
        logic [13:0] r;
        unique case (i)
            5'd0:    r = 14'd12868;
            5'd1:    r = 14'd7596;
            5'd2:    r = 14'd4014;
            5'd3:    r = 14'd2037;
            5'd4:    r = 14'd1023;
            5'd5:    r = 14'd512;
            5'd6:    r = 14'd256;
            5'd7:    r = 14'd128;
            5'd8:    r = 14'd64;
            5'd9:    r = 14'd32;
            5'd10:   r = 14'd16;
            5'd11:   r = 14'd8;
            5'd12:   r = 14'd4;
            5'd13:   r = 14'd2;
            5'd14:   r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pcsb_ram.sv
// ---------------------------------------------------------------------------
// pcsb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pcsb_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 61
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/pcsb_fifo.sv
// ---------------------------------------------------------------------------
// pcsb_fifo
// Short command queue between the classifier and the bin store.
// ---------------------------------------------------------------------------
`default_nettype none

module pcsb_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire pcsb_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output pcsb_pkg::cmd_t     pop_data,
    output logic               empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcsb_pkg::cmd_t slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                slot_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push && !full) - CW'(pop && !empty);
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcsb_front.sv
// ---------------------------------------------------------------------------
// pcsb_front
// Classifier: window tests, squared range, CORDIC angle and bin number.
// ---------------------------------------------------------------------------
`default_nettype none

module pcsb_front #(
    parameter int NUM_BINS     = 61,
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pcsb_pkg::in_t s_data,
    input  wire pcsb_pkg::cfg_t cfg,
    output logic               cmd_push,
    output pcsb_pkg::cmd_t     cmd_data,
    input  wire logic          cmd_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SQ   = 3'd1;
    localparam logic [2:0] F_CHK  = 3'd2;
    localparam logic [2:0] F_ROT  = 3'd3;
    localparam logic [2:0] F_ANG  = 3'd4;
    localparam logic [2:0] F_FIX  = 3'd5;
    localparam logic [2:0] F_PUSH = 3'd6;

    localparam logic signed [17:0] ANG_MAX = 18'(pcsb_pkg::ANG_LIMIT);
    localparam logic signed [17:0] ANG_MIN = -ANG_MAX;
    localparam int                 BW      = pcsb_pkg::BIN_IDX_W;

    logic [2:0]          state_reg;
    pcsb_pkg::in_t       item_reg;
    logic [30:0]         sqx_reg;
    logic [30:0]         sqz_reg;
    logic [25:0]         rmin_sq_reg;
    logic                keep_reg;
    logic [26:0]         rsq_reg;
    logic signed [28:0]  cx_reg;
    logic signed [28:0]  cy_reg;
    logic signed [17:0]  acc_reg;
    logic [4:0]          step_reg;
    logic [14:0]         off_reg;
    logic [41:0]         prod_reg;
    logic [BW-1:0]       bin_reg;

    logic signed [31:0]  px_sq;
    logic signed [31:0]  pz_sq;
    logic signed [16:0]  h;
    logic signed [16:0]  hmin;
    logic signed [16:0]  hmax;
    logic [31:0]         rsq;
    logic                plane_ok;
    logic                keep_chk;
    logic signed [28:0]  dx;
    logic signed [28:0]  dy;
    logic signed [17:0]  atan_ext;
    logic signed [17:0]  ang;
    logic signed [17:0]  ang_off;
    logic [6:0]          q0;
    logic [21:0]         rem;
    logic [6:0]          q1;
    logic [6:0]          q_clamp;

    always_comb begin
        px_sq    = item_reg.point_x * item_reg.point_x;
        pz_sq    = item_reg.point_z * item_reg.point_z;
        h        = -$signed({item_reg.point_y[15], item_reg.point_y});
        hmin     = $signed({cfg.min_height_mm[15], cfg.min_height_mm});
        hmax     = $signed({cfg.max_height_mm[15], cfg.max_height_mm});
        rsq      = {1'b0, sqx_reg} + {1'b0, sqz_reg};
        plane_ok = !item_reg.point_z[15]
                   && !((item_reg.point_z == '0) && (item_reg.point_x != '0));
        keep_chk = !item_reg.point_invalid && (h >= hmin) && (h <= hmax)
                   && (rsq >= {6'b0, rmin_sq_reg}) && plane_ok
                   && (rsq[31:27] == '0);
        dx       = cy_reg >>> step_reg;
        dy       = cx_reg >>> step_reg;
        atan_ext = $signed({4'b0, pcsb_pkg::atan_q14(step_reg)});
        ang      = -acc_reg;
        ang_off  = ang + ANG_MAX;
        q0       = prod_reg[41:pcsb_pkg::RECIP_SHIFT];
        rem      = {1'b0, off_reg, 6'b0} - 22'(22'(q0) * 22'(pcsb_pkg::BIN_WIDTH_Q20));
        q1       = q0 + 7'(rem >= 22'(pcsb_pkg::BIN_WIDTH_Q20));
        q_clamp  = (q1 > 7'(NUM_BINS - 1)) ? 7'(NUM_BINS - 1) : q1;
    end

    assign s_ready  = (state_reg == F_IDLE);
    assign cmd_push = (state_reg == F_PUSH) && !cmd_full;

    always_comb begin
        cmd_data.kind  = (item_reg.req_type == pcsb_pkg::REQ_COUNT)
                         ? pcsb_pkg::CMD_COUNT : pcsb_pkg::CMD_POINT;
        cmd_data.keep  = keep_reg;
        cmd_data.last  = item_reg.last_point;
        cmd_data.bin   = bin_reg;
        cmd_data.rsq   = rsq_reg;
        cmd_data.count = item_reg.visible_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= F_SQ;
                    end
                end
                F_SQ: begin
                    sqx_reg     <= 31'(px_sq);
                    sqz_reg     <= 31'(pz_sq);
                    rmin_sq_reg <= 26'(cfg.range_min_mm) * 26'(cfg.range_min_mm);
                    keep_reg    <= 1'b0;
                    state_reg   <= (item_reg.req_type == pcsb_pkg::REQ_COUNT) ? F_PUSH : F_CHK;
                end
                F_CHK: begin
                    keep_reg  <= keep_chk;
                    rsq_reg   <= rsq[26:0];
                    cx_reg    <= {{3{item_reg.point_z[15]}}, item_reg.point_z, 10'b0};
                    cy_reg    <= {{3{item_reg.point_x[15]}}, item_reg.point_x, 10'b0};
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= keep_chk ? F_ROT : F_PUSH;
                end
                F_ROT: begin
                    // rotate toward the x axis; a zero vector keeps acc at zero
                    if (item_reg.point_x == '0 && item_reg.point_z == '0) begin
                        state_reg <= F_ANG;
                    end else begin
                        if (!cy_reg[28]) begin
                            cx_reg  <= cx_reg + dx;
                            cy_reg  <= cy_reg - dy;
                            acc_reg <= acc_reg + atan_ext;
                        end else begin
                            cx_reg  <= cx_reg - dx;
                            cy_reg  <= cy_reg + dy;
                            acc_reg <= acc_reg - atan_ext;
                        end
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                            state_reg <= F_ANG;
                        end
                    end
                end
                F_ANG: begin
                    off_reg  <= ang_off[14:0];
                    prod_reg <= 42'({ang_off[14:0], 6'b0}) * 42'(pcsb_pkg::RECIP);
                    if (ang < ANG_MIN || ang > ANG_MAX) begin
                        keep_reg  <= 1'b0;
                        state_reg <= F_PUSH;
                    end else begin
                        state_reg <= F_FIX;
                    end
                end
                F_FIX: begin
                    bin_reg   <= BW'(q_clamp);
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (!cmd_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcsb_back.sv
// ---------------------------------------------------------------------------
// pcsb_back
// Bin store: nearest-range update, end-of-cloud square root and emission.
// ---------------------------------------------------------------------------
`default_nettype none

module pcsb_back #(
    parameter int NUM_BINS = 61
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    input  wire pcsb_pkg::cmd_t cmd_data,
    input  wire pcsb_pkg::cfg_t cfg,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pcsb_pkg::out_t      m_data
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DISP = 3'd1;
    localparam logic [2:0] B_UPD  = 3'd2;
    localparam logic [2:0] B_END  = 3'd3;
    localparam logic [2:0] B_LOAD = 3'd4;
    localparam logic [2:0] B_SQRT = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    localparam int AW = $clog2(NUM_BINS);
    localparam int SW = pcsb_pkg::SQ_W;

    logic [2:0]          state_reg;
    pcsb_pkg::cmd_t      cmd_reg;
    logic [15:0]         vis_reg;
    logic [NUM_BINS-1:0] valid_reg;
    logic [SW-1:0]       empty_reg;
    logic [AW-1:0]       idx_reg;
    logic [SW-1:0]       v_reg;
    logic [SW-1:0]       res_reg;
    logic [SW-1:0]       bit_reg;
    logic                m_valid_reg;
    pcsb_pkg::out_t      m_data_reg;

    logic [AW-1:0]       raddr;
    logic [SW-1:0]       rd_data;
    logic [AW-1:0]       cmd_bin;
    logic [SW-1:0]       cur_upd;
    logic [SW-1:0]       cur_load;
    logic                we;
    logic [SW:0]         trial;
    logic [13:0]         empty_mm;
    logic                out_free;
    logic                last_idx;

    assign cmd_bin  = cmd_reg.bin[AW-1:0];
    assign cur_upd  = valid_reg[cmd_bin] ? rd_data : empty_reg;
    assign cur_load = valid_reg[idx_reg] ? rd_data : empty_reg;
    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign empty_mm = 14'(cfg.range_max_mm) + 14'(pcsb_pkg::EMPTY_EXTRA);
    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = (idx_reg == AW'(NUM_BINS - 1));
    assign we       = (state_reg == B_UPD) && (cmd_reg.rsq < cur_upd);
    assign cmd_pop  = (state_reg == B_IDLE) && !cmd_empty;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        unique case (state_reg)
            B_DISP:  raddr = cmd_bin;
            B_OUT:   raddr = idx_reg + 1'b1;
            default: raddr = '0;
        endcase
    end

    pcsb_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk    (aclk),
        .we      (we),
        .waddr   (cmd_bin),
        .wdata   (cmd_reg.rsq),
        .raddr   (raddr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            vis_reg     <= '0;
            valid_reg   <= '0;
            empty_reg   <= SW'(pcsb_pkg::EMPTY_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            // load a new beat, or drop the current one once taken
            if (state_reg == B_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!cmd_empty) begin
                        cmd_reg   <= cmd_data;
                        state_reg <= B_DISP;
                    end
                end
                B_DISP: begin
                    if (cmd_reg.kind == pcsb_pkg::CMD_COUNT) begin
                        vis_reg   <= cmd_reg.count;
                        state_reg <= B_IDLE;
                    end else if (cmd_reg.keep) begin
                        state_reg <= B_UPD;
                    end else begin
                        state_reg <= cmd_reg.last ? B_END : B_IDLE;
                    end
                end
                B_UPD: begin
                    if (we) begin
                        valid_reg[cmd_bin] <= 1'b1;
                    end
                    state_reg <= cmd_reg.last ? B_END : B_IDLE;
                end
                B_END: begin
                    idx_reg <= '0;
                    if (vis_reg >= cfg.min_visible) begin
                        state_reg <= B_LOAD;
                    end else begin
                        // suppressed scan: drop the bins back to the empty marker
                        valid_reg <= '0;
                        empty_reg <= SW'(empty_mm) * SW'(empty_mm);
                        state_reg <= B_IDLE;
                    end
                end
                B_LOAD: begin
                    v_reg     <= cur_load;
                    res_reg   <= '0;
                    bit_reg   <= SW'(1) << (SW - 1);
                    state_reg <= B_SQRT;
                end
                B_SQRT: begin
                    if ({1'b0, v_reg} >= trial) begin
                        v_reg   <= v_reg - trial[SW-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == SW'(1)) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        m_data_reg.bin_index    <= 6'(idx_reg);
                        m_data_reg.bin_range_mm <= (res_reg > SW'(pcsb_pkg::RANGE_SAT))
                                                   ? 13'(pcsb_pkg::RANGE_SAT) : res_reg[12:0];
                        m_data_reg.last_bin     <= last_idx;
                        if (last_idx) begin
                            valid_reg <= '0;
                            empty_reg <= SW'(empty_mm) * SW'(empty_mm);
                            state_reg <= B_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_LOAD;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/point_cloud_to_scan_binner.sv
// ---------------------------------------------------------------------------
// point_cloud_to_scan_binner
// Projects a stream of 3D points onto a planar scan of angular bins.
// ---------------------------------------------------------------------------
// Input beats on s_* carry either a cloud point or a visible-feature count
// update. A classifier takes one beat at a time: height window, minimum
// range, then CORDIC_STEPS iterations of a single CORDIC stage for the
// angle, then a reciprocal multiply for the bin. Commands pass through a
// four-entry queue to the bin store, which keeps the nearest squared
// range of each bin in a RAM. After the last point of a cloud, if the
// count is high enough, the store emits NUM_BINS beats on m_*, bin 0
// first, each after one RAM read and 14 square-root steps; last_bin
// marks the final bin. m_ready low holds the result register and stalls
// the store, the queue then fills and s_ready drops. Reset leaves all
// bins at the 6000 mm empty marker with no clearing pass; each scan end
// refills them at once. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata.
// ---------------------------------------------------------------------------
`default_nettype none

module point_cloud_to_scan_binner #(
    parameter int NUM_BINS     = 61,
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pcsb_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pcsb_pkg::out_t      m_data,
    input  wire logic           cfg_wr_en,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_wdata
);

    pcsb_pkg::cfg_t cfg_reg;
    pcsb_pkg::cmd_t push_cmd;
    pcsb_pkg::cmd_t pop_cmd;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_height_mm <= 16'sd0;
            cfg_reg.max_height_mm <= 16'sd4000;
            cfg_reg.range_min_mm  <= 13'd450;
            cfg_reg.range_max_mm  <= 13'd5000;
            cfg_reg.min_visible   <= 16'd300;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcsb_pkg::CFG_MIN_HEIGHT:  cfg_reg.min_height_mm <= $signed(cfg_wdata);
                pcsb_pkg::CFG_MAX_HEIGHT:  cfg_reg.max_height_mm <= $signed(cfg_wdata);
                pcsb_pkg::CFG_RANGE_MIN:   cfg_reg.range_min_mm  <= cfg_wdata[12:0];
                pcsb_pkg::CFG_RANGE_MAX:   cfg_reg.range_max_mm  <= cfg_wdata[12:0];
                pcsb_pkg::CFG_MIN_VISIBLE: cfg_reg.min_visible   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pcsb_front #(
        .NUM_BINS     (NUM_BINS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg      (cfg_reg),
        .cmd_push (push),
        .cmd_data (push_cmd),
        .cmd_full (q_full)
    );

    pcsb_fifo #(
        .DEPTH (4)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    pcsb_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (q_empty),
        .cmd_pop   (pop),
        .cmd_data  (pop_cmd),
        .cfg       (cfg_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

>>> hdl/pcsb_checker.sv
// ---------------------------------------------------------------------------
// pcsb_checker
// Port-level checks on the scan output channel of the binner.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcsb_checker #(
    parameter int NUM_BINS = 61
) (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire pcsb_pkg::out_t m_data
);

    `PCSB_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result beat changed")
    `PCSB_ASSERT_ANY(a_out_reset, aclk, !aresetn |=> !m_valid, "result valid right after reset")
    `PCSB_ASSERT(a_last_flag, aclk, aresetn, m_valid |-> (m_data.last_bin == (m_data.bin_index == 6'(NUM_BINS - 1))), "last_bin disagrees with bin index")
    `PCSB_ASSERT(a_next_bin, aclk, aresetn, m_valid && m_ready && !m_data.last_bin ##1 m_valid |-> m_data.bin_index == $past(m_data.bin_index) + 6'd1, "bins out of order")

endmodule

bind point_cloud_to_scan_binner pcsb_checker #(
    .NUM_BINS (NUM_BINS)
) u_pcsb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
